### rtl/core/rpfa_pkg.sv
// Package for the row predicate filter: payload types, register map, codes and limits.
package rpfa_pkg;

   // Sizing of the scan and of the predicate.
   localparam int unsigned MAX_ROWS       = 65536;
   localparam int unsigned MAX_CONDITIONS = 4;

   // Field widths.
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 17;
   localparam int unsigned SUM_W    = 48;
   localparam int unsigned COND_W   = 3;
   localparam int unsigned CODE_W   = 3;
   localparam int unsigned SELECT_W = 4;
   localparam int unsigned CODES_W  = 12;
   localparam int unsigned JOIN_W   = 3;

   // Configuration port.
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;

   // The match count stops at the row limit, which never passes the count field's maximum.
   localparam int unsigned COUNT_MAX_RAW = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((MAX_ROWS > COUNT_MAX_RAW) ? COUNT_MAX_RAW : MAX_ROWS);

   // Clamped condition count.
   localparam logic [COND_W-1:0] COND_MAX = COND_W'(MAX_CONDITIONS);

   // Saturation bounds of the sums.
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Register indexes in address order.
   typedef enum logic [2:0] {
      REG_CONDITION_COUNT = 3'd0,
      REG_FIELD_SELECTS   = 3'd1,
      REG_COMPARE_CODES   = 3'd2,
      REG_JOIN_OPS        = 3'd3,
      REG_COMPARE_VALUE_0 = 3'd4,
      REG_COMPARE_VALUE_1 = 3'd5,
      REG_COMPARE_VALUE_2 = 3'd6,
      REG_COMPARE_VALUE_3 = 3'd7
   } reg_index_type;

   // Comparison codes; the two remaining codes make a condition false.
   typedef enum logic [CODE_W-1:0] {
      CMP_EQ = 3'd0,
      CMP_NE = 3'd1,
      CMP_GT = 3'd2,
      CMP_LT = 3'd3,
      CMP_GE = 3'd4,
      CMP_LE = 3'd5
   } cmp_code_type;

   // Join operators.
   localparam logic JOIN_OR  = 1'b0;
   localparam logic JOIN_AND = 1'b1;

   // Field select values.
   localparam logic SELECT_KEY = 1'b0;
   localparam logic SELECT_AGE = 1'b1;

   // Input row.
   typedef struct packed {
      logic signed [VALUE_W-1:0] row_key;
      logic signed [VALUE_W-1:0] row_age;
      logic                      end_of_scan;
   } req_type;

   // Result of one row.
   typedef struct packed {
      logic                      row_match;
      logic        [COUNT_W-1:0] match_count;
      logic signed [SUM_W-1:0]   key_sum;
      logic signed [SUM_W-1:0]   age_sum;
      logic                      scan_done;
   } rsp_type;

   // A row after the predicate stage.
   typedef struct packed {
      logic                      row_match;
      logic signed [VALUE_W-1:0] row_key;
      logic signed [VALUE_W-1:0] row_age;
      logic                      end_of_scan;
   } matched_type;

   // Saturating add of a signed row value to a signed sum.
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]   acc,
      input logic signed [VALUE_W-1:0] value
   );
      logic signed [SUM_W:0] total;
      logic signed [SUM_W-1:0] result;
      total = {acc[SUM_W-1], acc} + {{(SUM_W+1-VALUE_W){value[VALUE_W-1]}}, value};
      if (total[SUM_W] != total[SUM_W-1]) begin
         result = total[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         result = total[SUM_W-1:0];
      end
      return result;
   endfunction

endpackage

### rtl/core/row_predicate_filter_aggregate.sv
// Row predicate filter with running match count and key and age sums.
// Pipeline: a row accepted at the input passes the input, predicate and result registers on
// its way to the result port. Throughput: one row per cycle while rsp_ready is high; the
// accumulators update as rows leave the predicate stage; every stage advances when the next frees.
// Reset (synchronous): configuration registers and accumulators clear, all stages empty, ready
// high as soon as reset is released.
module row_predicate_filter_aggregate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rpfa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rpfa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rpfa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rpfa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rpfa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers.
   logic [rpfa_pkg::COND_W-1:0]           cond_count_ff;
   logic [rpfa_pkg::SELECT_W-1:0]         field_sel_ff;
   logic [rpfa_pkg::CODES_W-1:0]          cmp_codes_ff;
   logic [rpfa_pkg::JOIN_W-1:0]           join_ops_ff;
   logic signed [rpfa_pkg::VALUE_W-1:0]   cmp_value_ff [rpfa_pkg::MAX_CONDITIONS];

   // Pipeline stages.
   logic                                  in_valid_ff;
   rpfa_pkg::req_type                     in_ff;
   logic                                  mid_valid_ff;
   rpfa_pkg::matched_type                 mid_ff;
   rpfa_pkg::matched_type                 mid_in;
   logic                                  out_valid_ff;
   rpfa_pkg::rsp_type                     out_ff;
   rpfa_pkg::rsp_type                     out_in;

   // Accumulators.
   logic [rpfa_pkg::COUNT_W-1:0]          count_acc_ff;
   logic signed [rpfa_pkg::SUM_W-1:0]     key_acc_ff;
   logic signed [rpfa_pkg::SUM_W-1:0]     age_acc_ff;

   // Stage advance controls.
   logic                                  out_ready;
   logic                                  mid_ready;
   logic                                  in_move;
   logic                                  mid_move;
   logic                                  csr_write;
   rpfa_pkg::reg_index_type               csr_index;

   logic [rpfa_pkg::COND_W-1:0]           active_count;
   logic [rpfa_pkg::MAX_CONDITIONS-1:0]   cond_true;

   // A stage takes a new transaction when it is empty or its content moves on.
   assign out_ready = !out_valid_ff || rsp_ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign req_ready = !in_valid_ff || mid_ready;
   assign in_move   = in_valid_ff && mid_ready;
   assign mid_move  = mid_valid_ff && out_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Configuration port decode.
   assign csr_pready = 1'b1;
   assign csr_index  = rpfa_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register read back.
   always_comb begin
      unique case (csr_index)
         rpfa_pkg::REG_CONDITION_COUNT:
            csr_prdata = rpfa_pkg::CSR_DATA_W'(cond_count_ff);
         rpfa_pkg::REG_FIELD_SELECTS:
            csr_prdata = rpfa_pkg::CSR_DATA_W'(field_sel_ff);
         rpfa_pkg::REG_COMPARE_CODES:
            csr_prdata = rpfa_pkg::CSR_DATA_W'(cmp_codes_ff);
         rpfa_pkg::REG_JOIN_OPS:
            csr_prdata = rpfa_pkg::CSR_DATA_W'(join_ops_ff);
         rpfa_pkg::REG_COMPARE_VALUE_0: csr_prdata = cmp_value_ff[0];
         rpfa_pkg::REG_COMPARE_VALUE_1: csr_prdata = cmp_value_ff[1];
         rpfa_pkg::REG_COMPARE_VALUE_2: csr_prdata = cmp_value_ff[2];
         rpfa_pkg::REG_COMPARE_VALUE_3: csr_prdata = cmp_value_ff[3];
      endcase
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cond_count_ff <= '0;
         field_sel_ff  <= '0;
         cmp_codes_ff  <= '0;
         join_ops_ff   <= '0;
         for (int i = 0; i < rpfa_pkg::MAX_CONDITIONS; i++) begin
            cmp_value_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            rpfa_pkg::REG_CONDITION_COUNT:
               cond_count_ff <= csr_pwdata[rpfa_pkg::COND_W-1:0];
            rpfa_pkg::REG_FIELD_SELECTS:
               field_sel_ff <= csr_pwdata[rpfa_pkg::SELECT_W-1:0];
            rpfa_pkg::REG_COMPARE_CODES:
               cmp_codes_ff <= csr_pwdata[rpfa_pkg::CODES_W-1:0];
            rpfa_pkg::REG_JOIN_OPS:
               join_ops_ff <= csr_pwdata[rpfa_pkg::JOIN_W-1:0];
            rpfa_pkg::REG_COMPARE_VALUE_0: cmp_value_ff[0] <= csr_pwdata;
            rpfa_pkg::REG_COMPARE_VALUE_1: cmp_value_ff[1] <= csr_pwdata;
            rpfa_pkg::REG_COMPARE_VALUE_2: cmp_value_ff[2] <= csr_pwdata;
            rpfa_pkg::REG_COMPARE_VALUE_3: cmp_value_ff[3] <= csr_pwdata;
         endcase
      end
   end

   // One comparator per condition.
   always_comb begin
      logic signed [rpfa_pkg::VALUE_W-1:0] operand;
      for (int i = 0; i < rpfa_pkg::MAX_CONDITIONS; i++) begin
         operand = (field_sel_ff[i] == rpfa_pkg::SELECT_AGE) ? in_ff.row_age : in_ff.row_key;
         case (rpfa_pkg::cmp_code_type'(cmp_codes_ff[rpfa_pkg::CODE_W*i +: rpfa_pkg::CODE_W]))
            rpfa_pkg::CMP_EQ: cond_true[i] = (operand == cmp_value_ff[i]);
            rpfa_pkg::CMP_NE: cond_true[i] = (operand != cmp_value_ff[i]);
            rpfa_pkg::CMP_GT: cond_true[i] = (operand >  cmp_value_ff[i]);
            rpfa_pkg::CMP_LT: cond_true[i] = (operand <  cmp_value_ff[i]);
            rpfa_pkg::CMP_GE: cond_true[i] = (operand >= cmp_value_ff[i]);
            rpfa_pkg::CMP_LE: cond_true[i] = (operand <= cmp_value_ff[i]);
            default:          cond_true[i] = 1'b0;
         endcase
      end
   end

   // Fold the conditions left to right; an empty predicate passes every row.
   assign active_count = (cond_count_ff > rpfa_pkg::COND_MAX) ? rpfa_pkg::COND_MAX
                                                               : cond_count_ff;

   always_comb begin
      logic match;
      match = cond_true[0];
      for (int i = 1; i < rpfa_pkg::MAX_CONDITIONS; i++) begin
         if (rpfa_pkg::COND_W'(i) < active_count) begin
            if (join_ops_ff[i-1] == rpfa_pkg::JOIN_AND) begin
               match = match && cond_true[i];
            end else begin
               match = match || cond_true[i];
            end
         end
      end
      mid_in.row_match   = (active_count == '0) ? 1'b1 : match;
      mid_in.row_key     = in_ff.row_key;
      mid_in.row_age     = in_ff.row_age;
      mid_in.end_of_scan = in_ff.end_of_scan;
   end

   // Running totals including the row in the predicate register.
   always_comb begin
      out_in.row_match   = mid_ff.row_match;
      out_in.scan_done   = mid_ff.end_of_scan;
      out_in.match_count = count_acc_ff;
      out_in.key_sum     = key_acc_ff;
      out_in.age_sum     = age_acc_ff;
      if (mid_ff.row_match) begin
         if (count_acc_ff < rpfa_pkg::COUNT_LIMIT) begin
            out_in.match_count = count_acc_ff + 1'b1;
         end
         out_in.key_sum = rpfa_pkg::sat_add(key_acc_ff, mid_ff.row_key);
         out_in.age_sum = rpfa_pkg::sat_add(age_acc_ff, mid_ff.row_age);
      end
   end

   // Stage valid flags and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         count_acc_ff <= '0;
         key_acc_ff   <= '0;
         age_acc_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (mid_ready) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= mid_valid_ff;
         end
         if (mid_move) begin
            if (mid_ff.end_of_scan) begin
               count_acc_ff <= '0;
               key_acc_ff   <= '0;
               age_acc_ff   <= '0;
            end else begin
               count_acc_ff <= out_in.match_count;
               key_acc_ff   <= out_in.key_sum;
               age_acc_ff   <= out_in.age_sum;
            end
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (in_move) begin
         mid_ff <= mid_in;
      end
      if (mid_move) begin
         out_ff <= out_in;
      end
   end

   // The match count never passes its limit.
   assert property (@(posedge clock) disable iff (reset)
      count_acc_ff <= rpfa_pkg::COUNT_LIMIT)
      else $error("match count above its limit");

   // The last row of a scan leaves all accumulators cleared.
   assert property (@(posedge clock) disable iff (reset)
      (mid_move && mid_ff.end_of_scan)
      |=> (count_acc_ff == '0 && key_acc_ff == '0 && age_acc_ff == '0))
      else $error("accumulators not cleared after end of scan");

   // A row that fails the predicate leaves the count unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (mid_move && !mid_ff.row_match && !mid_ff.end_of_scan)
      |=> (count_acc_ff == $past(count_acc_ff)))
      else $error("count changed on a rejected row");

   // A matching result always reports a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.row_match) |-> (rsp_data.match_count != '0))
      else $error("matching row with zero count");

endmodule

### verif/tb_top.sv
// Testbench for the row predicate filter: directed and random scans checked against a predictor.
module tb_top;
   import rpfa_pkg::*;

   // Compare codes outside the defined set; a condition with one of them is false.
   localparam logic [CODE_W-1:0] CMP_VOID_LOW  = 3'd6;
   localparam logic [CODE_W-1:0] CMP_VOID_HIGH = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   // Rows in the random part, and how many at its end run with no idling.
   localparam int RANDOM_ROWS = 650;
   localparam int CALM_ROWS   = 120;

   // Cycles to let pass after the last result, beyond the three-stage pipeline.
   localparam int SETTLE_CYCLES = 6;

   // All-matching rows of extreme values in one long scan.
   localparam int LONG_SCAN_ROWS = 64;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicate settings as last written.
   logic [COND_W-1:0]         cfg_count   = '0;
   logic [SELECT_W-1:0]       cfg_selects = '0;
   logic [CODES_W-1:0]        cfg_codes   = '0;
   logic [JOIN_W-1:0]         cfg_joins   = '0;
   logic signed [VALUE_W-1:0] cfg_value [MAX_CONDITIONS] = '{default: '0};

   // Running totals of the current scan.
   logic [COUNT_W-1:0]      tally_count = '0;
   logic signed [SUM_W-1:0] tally_key   = '0;
   logic signed [SUM_W-1:0] tally_age   = '0;

   rsp_type expected_totals[$];
   int      mismatch_count = 0;
   int      rows_checked   = 0;
   bit      idle_on        = 1'b0;
   int      stall_left     = 0;

   row_predicate_filter_aggregate DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Evaluate one condition of the predicate on a row.
   function automatic logic condition_holds(input int unsigned idx,
                                            input logic signed [VALUE_W-1:0] key,
                                            input logic signed [VALUE_W-1:0] age);
      logic signed [VALUE_W-1:0] operand;
      logic signed [VALUE_W-1:0] limit;
      operand = (cfg_selects[idx] == SELECT_AGE) ? age : key;
      limit   = cfg_value[idx];
      case (cfg_codes[CODE_W*idx +: CODE_W])
         CMP_EQ: return operand == limit;
         CMP_NE: return operand != limit;
         CMP_GT: return operand > limit;
         CMP_LT: return operand < limit;
         CMP_GE: return operand >= limit;
         CMP_LE: return operand <= limit;
         default: return 1'b0;
      endcase
   endfunction

   // Add a row value to a sum, clamping at the signed 48-bit bounds.
   function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] total,
                                                         input logic signed [VALUE_W-1:0] addend);
      longint wide;
      wide = longint'(total) + longint'(addend);
      if (wide > longint'(SUM_MAX)) begin
         return SUM_MAX;
      end
      if (wide < longint'(SUM_MIN)) begin
         return SUM_MIN;
      end
      return wide[SUM_W-1:0];
   endfunction

   // Work out the result of one accepted row and advance the running totals.
   function automatic rsp_type predict_row(input req_type row);
      int unsigned active;
      logic        hit;
      rsp_type     outcome;
      active = (cfg_count > COND_MAX) ? COND_MAX : cfg_count;
      if (active == 0) begin
         hit = 1'b1;
      end else begin
         // Strictly left to right, no precedence between AND and OR.
         hit = condition_holds(0, row.row_key, row.row_age);
         for (int unsigned i = 1; i < active; i++) begin
            if (cfg_joins[i-1] == JOIN_AND) begin
               hit = hit & condition_holds(i, row.row_key, row.row_age);
            end else begin
               hit = hit | condition_holds(i, row.row_key, row.row_age);
            end
         end
      end
      if (hit) begin
         if (tally_count < COUNT_LIMIT) begin
            tally_count++;
         end
         tally_key = clamp_sum(tally_key, row.row_key);
         tally_age = clamp_sum(tally_age, row.row_age);
      end
      outcome.row_match   = hit;
      outcome.match_count = tally_count;
      outcome.key_sum     = tally_key;
      outcome.age_sum     = tally_age;
      outcome.scan_done   = row.end_of_scan;
      // The end mark closes the scan: totals start over with the next row.
      if (row.end_of_scan) begin
         tally_count = '0;
         tally_key   = '0;
         tally_age   = '0;
      end
      return outcome;
   endfunction

   function automatic req_type make_row(input logic signed [VALUE_W-1:0] key,
                                        input logic signed [VALUE_W-1:0] age,
                                        input logic last);
      req_type row;
      row.row_key     = key;
      row.row_age     = age;
      row.end_of_scan = last;
      return row;
   endfunction

   // Pick a value that often lands on an extreme or next to a compare constant.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] near;
      int                        offset;
      near   = cfg_value[$urandom_range(0, MAX_CONDITIONS - 1)];
      offset = int'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 6))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return near;
         3: return near + offset;
         4: return int'($urandom_range(0, 200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Send one row and record its expected result at the edge where it is accepted.
   task automatic send_row(input req_type row);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_totals.push_back(predict_row(row));
   endtask

   // Hold off the input until every expected result has come and the pipeline is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic write_reg(input reg_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_CONDITION_COUNT: cfg_count    = value[COND_W-1:0];
         REG_FIELD_SELECTS:   cfg_selects  = value[SELECT_W-1:0];
         REG_COMPARE_CODES:   cfg_codes    = value[CODES_W-1:0];
         REG_JOIN_OPS:        cfg_joins    = value[JOIN_W-1:0];
         REG_COMPARE_VALUE_0: cfg_value[0] = value;
         REG_COMPARE_VALUE_1: cfg_value[1] = value;
         REG_COMPARE_VALUE_2: cfg_value[2] = value;
         REG_COMPARE_VALUE_3: cfg_value[3] = value;
      endcase
   endtask

   task automatic write_predicate(input logic [COND_W-1:0] count,
                                  input logic [SELECT_W-1:0] selects,
                                  input logic [CODES_W-1:0] codes,
                                  input logic [JOIN_W-1:0] joins,
                                  input logic [CSR_DATA_W-1:0] value0,
                                  input logic [CSR_DATA_W-1:0] value1,
                                  input logic [CSR_DATA_W-1:0] value2,
                                  input logic [CSR_DATA_W-1:0] value3);
      write_reg(REG_CONDITION_COUNT, CSR_DATA_W'(count));
      write_reg(REG_FIELD_SELECTS, CSR_DATA_W'(selects));
      write_reg(REG_COMPARE_CODES, CSR_DATA_W'(codes));
      write_reg(REG_JOIN_OPS, CSR_DATA_W'(joins));
      write_reg(REG_COMPARE_VALUE_0, value0);
      write_reg(REG_COMPARE_VALUE_1, value1);
      write_reg(REG_COMPARE_VALUE_2, value2);
      write_reg(REG_COMPARE_VALUE_3, value3);
   endtask

   // Reset settings pass every row; the extremes of both columns go through.
   task automatic test_pass_all();
      send_row(make_row(VALUE_MAX, VALUE_MIN, 1'b0));
      send_row(make_row(VALUE_MIN, VALUE_MAX, 1'b0));
      send_row(make_row(-32'sd1, 32'sd0, 1'b1));
      wait_idle();
   endtask

   // One age condition, stepped through every compare code including the two false ones.
   task automatic test_each_compare();
      logic [CODE_W-1:0] code_list [8];
      code_list = '{CMP_EQ, CMP_NE, CMP_GT, CMP_LT, CMP_GE, CMP_LE,
                    CMP_VOID_LOW, CMP_VOID_HIGH};
      write_predicate(3'd1, {3'b000, SELECT_AGE}, '0, '0, -32'sd5, '0, '0, '0);
      foreach (code_list[i]) begin
         write_reg(REG_COMPARE_CODES, CSR_DATA_W'(code_list[i]));
         send_row(make_row(32'sd7, -32'sd5, 1'b0));
         send_row(make_row(-32'sd9, (i % 2) ? -32'sd6 : -32'sd4, i == 7));
         wait_idle();
      end
   endtask

   // Four conditions with mixed joins and extreme constants.
   task automatic test_join_chain();
      write_predicate(3'd4, {SELECT_AGE, SELECT_KEY, SELECT_AGE, SELECT_KEY},
                      {CMP_GT, CMP_NE, CMP_LT, CMP_GE}, {JOIN_AND, JOIN_OR, JOIN_AND},
                      32'sd0, 32'sd100, VALUE_MAX, VALUE_MIN);
      send_row(make_row(32'sd5, 32'sd50, 1'b0));
      send_row(make_row(-32'sd5, 32'sd200, 1'b0));
      send_row(make_row(VALUE_MAX, VALUE_MIN, 1'b0));
      send_row(make_row(32'sd0, VALUE_MAX, 1'b1));
      wait_idle();
   endtask

   // A condition count above four behaves as four.
   task automatic test_condition_clamp();
      write_reg(REG_CONDITION_COUNT, CSR_DATA_W'(7));
      send_row(make_row(32'sd1, 32'sd1, 1'b0));
      send_row(make_row(-32'sd1, 32'sd100, 1'b1));
      wait_idle();
   endtask

   // A long back-to-back scan of extreme values, closed by a few smaller rows.
   task automatic test_long_scan();
      idle_on = 1'b0;
      write_predicate('0, '0, '0, '0, '0, '0, '0, '0);
      for (int r = 0; r < LONG_SCAN_ROWS; r++) begin
         send_row(make_row(VALUE_MAX, VALUE_MIN, 1'b0));
      end
      for (int r = 1; r <= 6; r++) begin
         send_row(make_row(-32'sd1000 * r, 32'sd1000 * r, r == 6));
      end
      wait_idle();
   endtask

   // Random predicates, each followed by a scan of random rows.
   task automatic test_random_scans();
      int                sent;
      int                scan_rows;
      bit                closed;
      logic [CODES_W-1:0] codes;
      sent = 0;
      while (sent < RANDOM_ROWS) begin
         wait_idle();
         idle_on = (sent < RANDOM_ROWS - CALM_ROWS) && ($urandom_range(0, 3) != 0);
         for (int c = 0; c < MAX_CONDITIONS; c++) begin
            if ($urandom_range(0, 9) == 0) begin
               codes[CODE_W*c +: CODE_W] = $urandom_range(0, 1) ? CMP_VOID_LOW : CMP_VOID_HIGH;
            end else begin
               codes[CODE_W*c +: CODE_W] = CODE_W'($urandom_range(CMP_EQ, CMP_LE));
            end
         end
         write_predicate(COND_W'($urandom_range(0, 7)), SELECT_W'($urandom), codes,
                         JOIN_W'($urandom), pick_value(), pick_value(), pick_value(),
                         pick_value());
         // Mostly complete scans; some carry a stray end mark or none at all.
         scan_rows = $urandom_range(1, 40);
         closed    = $urandom_range(0, 7) != 0;
         for (int r = 0; r < scan_rows; r++) begin
            send_row(make_row(pick_value(), pick_value(),
                              (closed && r == scan_rows - 1) || $urandom_range(0, 24) == 0));
            sent++;
         end
      end
   endtask

   // Result side: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 4);
      end
      rsp_ready <= (stall_left == 0);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rows_checked++;
         if (expected_totals.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", rows_checked));
         end else begin
            want = expected_totals.pop_front();
            if (rsp_data.row_match !== want.row_match) begin
               report_mismatch($sformatf("result %0d row_match: got %b expected %b",
                                         rows_checked, rsp_data.row_match, want.row_match));
            end
            if (rsp_data.match_count !== want.match_count) begin
               report_mismatch($sformatf("result %0d match_count: got %0d expected %0d",
                                         rows_checked, rsp_data.match_count, want.match_count));
            end
            if (rsp_data.key_sum !== want.key_sum) begin
               report_mismatch($sformatf("result %0d key_sum: got %0d expected %0d",
                                         rows_checked, rsp_data.key_sum, want.key_sum));
            end
            if (rsp_data.age_sum !== want.age_sum) begin
               report_mismatch($sformatf("result %0d age_sum: got %0d expected %0d",
                                         rows_checked, rsp_data.age_sum, want.age_sum));
            end
            if (rsp_data.scan_done !== want.scan_done) begin
               report_mismatch($sformatf("result %0d scan_done: got %b expected %b",
                                         rows_checked, rsp_data.scan_done, want.scan_done));
            end
         end
      end
   end

   // Reset, the tests in turn, then the verdict.
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_pass_all();
      test_each_compare();
      test_join_chain();
      test_condition_clamp();
      test_long_scan();
      test_random_scans();
      idle_on = 1'b0;
      wait_idle();
      if (mismatch_count == 0 && expected_totals.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
